FILE: rtl/text_line_layout_aligner_defines.svh
// Assertion macros used by the layout aligner module.
`ifndef TEXT_LINE_LAYOUT_ALIGNER_DEFINES_SVH
`define TEXT_LINE_LAYOUT_ALIGNER_DEFINES_SVH

// Checks that an antecedent implies a consequent in the following cycle.
`define TLA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Checks that an antecedent implies a consequent in the same cycle.
`define TLA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/tla_pkg.sv
package tla_pkg;

    localparam int LineDepth  = 64;
    localparam int GlyphCount = 95;
    localparam int FracBits   = 8;
    localparam int FillW      = $clog2(LineDepth + 1);
    localparam int IdxW       = $clog2(LineDepth);
    localparam int GlyphW     = $clog2(GlyphCount);

    localparam logic [6:0] NewlineCode    = 7'd10;
    localparam logic [6:0] FirstPrintable = 7'd32;
    localparam logic signed [23:0] PosMax = 24'sh7FFFFF;
    localparam logic signed [23:0] PosMin = -24'sh800000;

    localparam logic [2:0] RegOriginX = 3'd0;
    localparam logic [2:0] RegOriginY = 3'd1;
    localparam logic [2:0] RegAlignH  = 3'd2;
    localparam logic [2:0] RegAlignV  = 3'd3;
    localparam logic [2:0] RegPitch   = 3'd4;
    localparam logic [2:0] RegTotal   = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_PLACE,
        ST_H_MUL,
        ST_V_MUL1,
        ST_V_MUL2,
        ST_RD,
        ST_EMIT,
        ST_WAIT,
        ST_AFTER
    } state_t;

    typedef enum logic [1:0] {
        MUL_H,
        MUL_V1,
        MUL_V2
    } mul_sel_t;

    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        if (v > 28'(PosMax)) begin
            return PosMax;
        end else if (v < 28'(PosMin)) begin
            return PosMin;
        end
        return v[23:0];
    endfunction

    function automatic logic signed [23:0] sat24w(input logic signed [33:0] v);
        if (v > 34'(PosMax)) begin
            return PosMax;
        end else if (v < 34'(PosMin)) begin
            return PosMin;
        end
        return v[23:0];
    endfunction

endpackage

FILE: rtl/tla_mul.sv
module tla_mul
    import tla_pkg::*;
(
    input  logic                aclk,
    input  logic signed [32:0]  op_a,
    input  logic signed [16:0]  op_b,
    output logic signed [49:0]  prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= 50'(op_a) * 50'(op_b);
    end

endmodule

FILE: rtl/text_line_layout_aligner.sv
// Channel  Direction  tdata fields (low bit first)          tuser
// s_       in         char_code, off_x, off_y, advance      func, end_of_string
// m_       out        out_char, pos_x, pos_y                last_of_line, line_overflow
// cfg_     in         cfg_index selects register, cfg_data value
// A load is accepted in ST_IDLE; any other non-newline character goes through accept,
// metric read and placement. Closing a line runs the multiplications, then for each stored
// character the registered line store read and the output register, then ST_AFTER.
// The output stalls the sequencer only; aresetn clears pen, fill and control state.
`include "text_line_layout_aligner_defines.svh"
module text_line_layout_aligner
    import tla_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // char_code[6:0], glyph_off_x, glyph_off_y, glyph_advance
    input  logic [1:0]  s_tuser,   // func, end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_char[6:0], pos_x[30:7], pos_y[54:31], zero
    output logic [1:0]  m_tuser,   // last_of_line, line_overflow
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    state_t state_reg, state_next;

    logic signed [23:0] origin_x_reg, origin_y_reg;
    logic [8:0]  align_h_reg, align_v_reg;
    logic [15:0] pitch_reg;
    logic [11:0] total_reg;

    logic signed [15:0] mox [GlyphCount];
    logic signed [15:0] moy [GlyphCount];
    logic [15:0]        madv[GlyphCount];
    logic [6:0]         lcode[LineDepth];
    logic signed [23:0] lx[LineDepth];
    logic signed [23:0] ly[LineDepth];

    logic signed [23:0] pen_x_reg, pen_y_reg;
    logic [FillW-1:0]   fill_reg;
    logic               drop_reg;

    logic [6:0]  code_reg;
    logic        eos_reg;
    logic        nl_reg;
    logic signed [15:0] gox_reg, goy_reg;
    logic [15:0] gadv_reg;
    logic signed [25:0] hshift_reg;
    logic signed [31:0] vshift_reg;
    logic [FillW-1:0] rd_reg;
    logic [6:0]  rcode_reg;
    logic signed [23:0] rx_reg, ry_reg;
    logic        rlast_reg;

    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic [1:0]  out_user_reg;

    logic [6:0]  in_code;
    logic        printable, cur_print;
    logic [GlyphW-1:0] in_idx, cur_idx;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] prod;
    mul_sel_t    mul_sel;
    logic        accept;

    assign in_code   = s_tdata[6:0];
    assign printable = (in_code >= FirstPrintable) &&
                       ({1'b0, in_code} - {1'b0, FirstPrintable} < 8'(GlyphCount));
    assign in_idx    = GlyphW'(in_code - FirstPrintable);
    assign cur_print = (code_reg >= FirstPrintable) &&
                       ({1'b0, code_reg} - {1'b0, FirstPrintable} < 8'(GlyphCount));
    assign cur_idx   = GlyphW'(code_reg - FirstPrintable);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    always_comb begin
        unique case (state_reg)
            ST_V_MUL1: mul_sel = MUL_V1;
            ST_V_MUL2: mul_sel = MUL_V2;
            default:   mul_sel = MUL_H;
        endcase
        unique case (mul_sel)
            MUL_H: begin
                mul_a = 33'(pen_x_reg);
                mul_b = 17'({8'd0, align_h_reg});
            end
            MUL_V1: begin
                mul_a = 33'({21'd0, total_reg});
                mul_b = 17'({1'b0, pitch_reg});
            end
            default: begin
                mul_a = prod[32:0];
                mul_b = 17'({8'd0, align_v_reg});
            end
        endcase
    end

    tla_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .prod_reg(prod)
    );

    logic signed [49:0] prod_r;
    assign prod_r = (prod + 50'sd128) >>> 8;

    always_ff @(posedge aclk) begin
        if (accept && !s_tuser[0] && printable) begin
            mox[in_idx]  <= s_tdata[22:7];
            moy[in_idx]  <= s_tdata[38:23];
            madv[in_idx] <= s_tdata[54:39];
        end
        if (state_reg == ST_LOOK) begin
            gox_reg  <= mox[cur_idx];
            goy_reg  <= moy[cur_idx];
            gadv_reg <= madv[cur_idx];
        end
        if (state_reg == ST_PLACE && cur_print && fill_reg < FillW'(LineDepth)) begin
            lcode[fill_reg[IdxW-1:0]] <= code_reg;
            lx[fill_reg[IdxW-1:0]] <= sat24(28'(origin_x_reg) + 28'(pen_x_reg)
                                            + (28'(gox_reg) <<< FracBits));
            ly[fill_reg[IdxW-1:0]] <= sat24(28'(origin_y_reg) + 28'(pen_y_reg)
                                            + (28'(goy_reg) <<< FracBits));
        end
        if (state_reg == ST_RD) begin
            rcode_reg <= lcode[rd_reg[IdxW-1:0]];
            rx_reg    <= lx[rd_reg[IdxW-1:0]];
            ry_reg    <= ly[rd_reg[IdxW-1:0]];
            rlast_reg <= (rd_reg + 1'b1 == fill_reg);
        end
        if (accept) begin
            code_reg <= in_code;
            eos_reg  <= s_tuser[1];
            nl_reg   <= (in_code == NewlineCode);
        end
        if (state_reg == ST_AFTER) begin
            nl_reg <= 1'b0;
        end
        if (state_reg == ST_V_MUL1) begin
            hshift_reg <= prod_r[25:0];
        end
        if (state_reg == ST_RD && rd_reg == '0) begin
            vshift_reg <= prod_r[31:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept && s_tuser[0]) begin
                state_next = (in_code == NewlineCode) ? ST_H_MUL : ST_LOOK;
            end
            ST_LOOK:   state_next = ST_PLACE;
            ST_PLACE:  state_next = eos_reg ? ST_H_MUL : ST_IDLE;
            ST_H_MUL:  state_next = ST_V_MUL1;
            ST_V_MUL1: state_next = ST_V_MUL2;
            ST_V_MUL2: state_next = (fill_reg == '0) ? ST_AFTER : ST_RD;
            ST_RD:     state_next = ST_EMIT;
            ST_EMIT:   if (!out_valid_reg || m_tready) begin
                state_next = rlast_reg ? ST_AFTER : ST_RD;
            end
            ST_WAIT:   state_next = ST_IDLE;
            ST_AFTER:  state_next = (nl_reg && eos_reg) ? ST_H_MUL : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    logic signed [24:0] pen_adv;
    logic signed [24:0] pen_ny;
    assign pen_adv = 25'(pen_x_reg) + 25'({1'b0, gadv_reg});
    assign pen_ny  = 25'(pen_y_reg) + 25'({1'b0, pitch_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            align_h_reg   <= '0;
            align_v_reg   <= '0;
            pitch_reg     <= '0;
            total_reg     <= 12'd1;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    RegOriginX: origin_x_reg <= cfg_data;
                    RegOriginY: origin_y_reg <= cfg_data;
                    RegAlignH:  align_h_reg  <= cfg_data[8:0];
                    RegAlignV:  align_v_reg  <= cfg_data[8:0];
                    RegPitch:   pitch_reg    <= cfg_data[15:0];
                    RegTotal:   total_reg    <= cfg_data[11:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_PLACE && cur_print) begin
                if (fill_reg < FillW'(LineDepth)) begin
                    fill_reg <= fill_reg + 1'b1;
                end else begin
                    drop_reg <= 1'b1;
                end
                pen_x_reg <= (pen_adv > 25'(PosMax)) ? PosMax : pen_adv[23:0];
            end
            if (state_reg == ST_V_MUL2) begin
                rd_reg <= '0;
            end
            if (state_reg == ST_EMIT && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {1'b0,
                    sat24w(34'(ry_reg) - 34'(vshift_reg)),
                    sat24w(34'(rx_reg) - 34'(hshift_reg)), rcode_reg};
                out_user_reg  <= {drop_reg, rlast_reg};
                rd_reg        <= rd_reg + 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_AFTER || (state_reg == ST_V_MUL2 && fill_reg == '0)) begin
                fill_reg <= '0;
                drop_reg <= 1'b0;
            end
            if (state_reg == ST_AFTER) begin
                if (nl_reg) begin
                    pen_x_reg <= '0;
                    if (eos_reg) begin
                        pen_y_reg <= '0;
                    end else begin
                        pen_y_reg <= (pen_ny > 25'(PosMax)) ? PosMax : pen_ny[23:0];
                    end
                end else begin
                    pen_x_reg <= '0;
                    pen_y_reg <= '0;
                end
            end
        end
    end

    `TLA_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FillW'(LineDepth))
    `TLA_ASSERT_NOW(a_busy_no_in, aclk, aresetn, state_reg != ST_IDLE, !s_tready)
    `TLA_ASSERT_NEXT(a_emit_valid, aclk, aresetn,
                     state_reg == ST_EMIT && (!out_valid_reg || m_tready), m_tvalid)

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import tla_pkg::*;

    typedef struct {
        bit [6:0]  ch;
        bit [23:0] x;
        bit [23:0] y;
        bit        last;
        bit        ovf;
    } placed_t;

    typedef struct {
        bit        func;
        bit [6:0]  code;
        bit [15:0] offx;
        bit [15:0] offy;
        bit [15:0] adv;
        bit        eos;
        bit        typed;
        placed_t   want;
    } char_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    text_line_layout_aligner uut (.*);

    always #5 aclk = ~aclk;

    char_beat_t text_q[$];
    placed_t    placed_q[$];
    char_beat_t cur_beat;
    int         errors = 0;
    int         send_idle = 0;
    int         recv_stall = 0;

    // Shadow of the block's registers and state.
    longint     org_x, org_y, pen_x, pen_y;
    int         al_h, al_v, pitch, total;
    longint     gx[GlyphCount], gy[GlyphCount];
    int         gadv[GlyphCount];
    bit [6:0]   row_code[LineDepth];
    longint     row_x[LineDepth], row_y[LineDepth];
    int         fill;
    bit         dropped;
    bit         glyph_ready[GlyphCount];

    function automatic longint sat24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic flush_line(ref placed_t outs[$]);
        longint hs, vs;
        placed_t p;
        hs = (pen_x * al_h + 128) >>> 8;
        vs = (longint'(total) * pitch * al_v + 128) >>> 8;
        for (int j = 0; j < fill; j++) begin
            p.ch = row_code[j];
            p.x = 24'(sat24(row_x[j] - hs));
            p.y = 24'(sat24(row_y[j] - vs));
            p.last = (j + 1 == fill);
            p.ovf = dropped;
            outs.push_back(p);
        end
        fill = 0;
        dropped = 0;
    endtask

    task automatic place_char(char_beat_t b);
        placed_t outs[$];
        bit prn;
        int gi;
        prn = b.code >= 32 && b.code <= 126;
        gi = prn ? b.code - 32 : 0;
        if (!b.func) begin
            if (prn) begin
                gx[gi] = longint'($signed(b.offx));
                gy[gi] = longint'($signed(b.offy));
                gadv[gi] = b.adv;
            end
            return;
        end
        if (b.code == NewlineCode) begin
            flush_line(outs);
            pen_x = 0;
            pen_y = pen_y + pitch;
            if (pen_y > 8388607) pen_y = 8388607;
        end else if (prn) begin
            if (fill < LineDepth) begin
                row_code[fill] = b.code;
                row_x[fill] = sat24(org_x + pen_x + gx[gi] * 256);
                row_y[fill] = sat24(org_y + pen_y + gy[gi] * 256);
                fill++;
            end else begin
                dropped = 1;
            end
            pen_x = pen_x + gadv[gi];
            if (pen_x > 8388607) pen_x = 8388607;
        end
        if (b.eos) begin
            flush_line(outs);
            pen_x = 0;
            pen_y = 0;
        end
        if (b.typed) begin
            placed_q.push_back(b.want);
        end else begin
            foreach (outs[k]) placed_q.push_back(outs[k]);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) place_char(cur_beat);
            if (!s_tvalid || s_tready) begin
                if (text_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_beat = text_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, cur_beat.adv, cur_beat.offy, cur_beat.offx, cur_beat.code};
                    s_tuser <= {cur_beat.eos, cur_beat.func};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        placed_t w;
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall);
        if (aresetn && m_tvalid && m_tready) begin
            if (placed_q.size() == 0) begin
                report("unexpected beat, char", m_tdata[6:0], -1);
            end else begin
                w = placed_q.pop_front();
                if (m_tdata[6:0] != w.ch) report("out_char", m_tdata[6:0], w.ch);
                if (m_tdata[30:7] != w.x)
                    report("pos_x", $signed(m_tdata[30:7]), $signed(w.x));
                if (m_tdata[54:31] != w.y)
                    report("pos_y", $signed(m_tdata[54:31]), $signed(w.y));
                if (m_tuser[0] != w.last) report("last_of_line", m_tuser[0], w.last);
                if (m_tuser[1] != w.ovf) report("line_overflow", m_tuser[1], w.ovf);
            end
        end
    end

    function automatic char_beat_t mk(bit func, bit [6:0] code, bit [15:0] offx,
                                      bit [15:0] offy, bit [15:0] adv, bit eos);
        char_beat_t b;
        b = '{func, code, offx, offy, adv, eos, 1'b0, '{0, 0, 0, 0, 0}};
        return b;
    endfunction

    task automatic push_beat(char_beat_t b);
        if (!b.func && b.code >= 32 && b.code <= 126) glyph_ready[b.code - 32] = 1;
        text_q.push_back(b);
    endtask

    task automatic push_glyph(bit [6:0] code);
        bit [15:0] adv;
        adv = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
        push_beat(mk(0, code, 16'($urandom), 16'($urandom), adv, 0));
    endtask

    task automatic push_char(bit [6:0] code, bit eos);
        if (!glyph_ready[code - 32] || $urandom_range(19) == 0) push_glyph(code);
        push_beat(mk(1, code, 16'($urandom), 16'($urandom), 16'($urandom), eos));
    endtask

    task automatic make_text(int n);
        int sent, len;
        bit [6:0] c;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(9) == 0) begin
                c = 7'($urandom);
                if (c >= 32 && c <= 126 && !glyph_ready[c - 32]) c = 7'd127;
                push_beat(mk($urandom_range(1), c, 16'($urandom), 16'($urandom),
                             16'($urandom), $urandom_range(3) == 0));
                sent++;
            end else begin
                len = ($urandom_range(24) == 0) ? $urandom_range(64, 70) : $urandom_range(0, 9);
                for (int k = 0; k < len; k++) push_char(7'($urandom_range(32, 126)), 0);
                if ($urandom_range(2) == 0) begin
                    push_beat(mk(1, NewlineCode, 16'($urandom), 16'($urandom), 16'($urandom),
                                 $urandom_range(4) == 0));
                end else begin
                    push_char(7'($urandom_range(32, 126)), 1);
                end
                sent += len + 1;
            end
        end
    endtask

    task automatic write_regs(logic [23:0] v[6]);
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= v[i];
            @(posedge aclk);
            while (!(cfg_valid && cfg_ready)) @(posedge aclk);
            case (3'(i))
                RegOriginX: org_x = longint'($signed(v[i]));
                RegOriginY: org_y = longint'($signed(v[i]));
                RegAlignH:  al_h = v[i][8:0];
                RegAlignV:  al_v = v[i][8:0];
                RegPitch:   pitch = v[i][15:0];
                RegTotal:   total = v[i][11:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (text_q.size() > 0 || s_tvalid || placed_q.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        char_beat_t table_rows[$];
        char_beat_t b;
        logic [23:0] regs[6];
        int idles[5][2];
        org_x = 0; org_y = 0; al_h = 0; al_v = 0; pitch = 0; total = 1;
        pen_x = 0; pen_y = 0; fill = 0; dropped = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        b = mk(0, 65, 0, 0, 256, 0);                    table_rows.push_back(b);
        b = mk(1, 65, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1); b.typed = 1;
        b.want = '{65, 0, 0, 1, 0};                    table_rows.push_back(b);
        b = mk(0, 33, 16'h8000, 16'h7FFF, 16'hFFFF, 0); table_rows.push_back(b);
        b = mk(1, 33, 0, 0, 0, 1);                      b.typed = 1;
        b.want = '{33, 24'h800000, 24'h7FFF00, 1, 0};  table_rows.push_back(b);
        table_rows.push_back(mk(0, 126, 16'h7FFF, 16'h8000, 0, 0));
        table_rows.push_back(mk(0, 32, 5, 16'hFFFB, 16'h0380, 1));
        table_rows.push_back(mk(0, 5, 1, 1, 1, 0));
        table_rows.push_back(mk(0, 127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
        table_rows.push_back(mk(0, NewlineCode, 3, 3, 3, 1));
        table_rows.push_back(mk(1, 0, 0, 0, 0, 1));
        table_rows.push_back(mk(1, NewlineCode, 0, 0, 0, 0));
        table_rows.push_back(mk(1, 32, 0, 0, 0, 0));
        table_rows.push_back(mk(1, 126, 0, 0, 0, 0));
        table_rows.push_back(mk(1, 127, 0, 0, 0, 0));
        table_rows.push_back(mk(1, 65, 0, 0, 0, 0));
        table_rows.push_back(mk(1, NewlineCode, 0, 0, 0, 0));
        table_rows.push_back(mk(1, 33, 0, 0, 0, 0));
        table_rows.push_back(mk(1, 7'd31, 0, 0, 0, 0));
        table_rows.push_back(mk(1, NewlineCode, 0, 0, 0, 1));
        table_rows.push_back(mk(1, 7'd31, 0, 0, 0, 1));
        foreach (table_rows[i]) push_beat(table_rows[i]);
        drain();

        idles = '{'{0, 0}, '{75, 0}, '{0, 75}, '{35, 35}, '{0, 0}};
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 4) begin
                regs = '{24'h7FFFFF, 24'h800000, 24'd256, 24'd511, 24'hFFFF, 24'hFFF};
            end else if (ph == 3) begin
                regs = '{24'h800000, 24'h7FFFFF, 24'd0, 24'd256, 24'd0, 24'd0};
            end else begin
                regs = '{24'($urandom), 24'($urandom_range(0, 65535)),
                         24'($urandom_range(0, 256)), 24'($urandom_range(0, 256)),
                         24'($urandom_range(0, 8192)), 24'($urandom_range(1, 40))};
            end
            write_regs(regs);
            send_idle = idles[ph][0];
            recv_stall = idles[ph][1];
            make_text(36);
            drain();
        end

        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/tla_pkg.sv
rtl/tla_mul.sv
rtl/text_line_layout_aligner.sv
dv/tb_top.sv
